### src/cwg_pkg.sv
// cwg_pkg: types and constants used by conv1d_window_geometry_unit
// no dependencies
package cwg_pkg;

    localparam int CFG_W   = 16;
    localparam int LEN_W   = 16;
    localparam int K_W     = 8;
    localparam int OLEN_W  = 17;
    localparam int DIV_W   = 17;
    localparam int START_W = 26;

    typedef enum logic [2:0] {
        CFG_INPUT_LENGTH     = 3'd0,
        CFG_KERNEL_SIZE      = 3'd1,
        CFG_STRIDE           = 3'd2,
        CFG_DILATION         = 3'd3,
        CFG_PADDING_MODE     = 3'd4,
        CFG_EXPLICIT_PADDING = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PAD_VALID    = 2'd0,
        PAD_SAME     = 2'd1,
        PAD_EXPLICIT = 2'd2
    } t_pad_mode;

    // geometry carried through the output-length divider
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [K_W-1:0]    ks;
        logic [K_W-1:0]    st;
        logic [K_W-1:0]    dl;
        logic [OLEN_W-1:0] eff;
        logic [23:0]       pp;
        logic [1:0]        mode;
        logic [K_W-1:0]    ep;
        logic              ok;
    } t_geo;

    // window data carried through the last-tap divider
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [K_W-1:0]     ks;
        logic [K_W-1:0]     dl;
        logic               neg;
        logic               inr;
        logic [OLEN_W-1:0]  outlen;
        logic [LEN_W-1:0]   lpad;
        logic [LEN_W-1:0]   rpad;
    } t_win;

endpackage

### src/conv1d_window_geometry_unit.sv
// conv1d_window_geometry_unit: window descriptor generator for a 1-D convolution
// depends on cwg_pkg and cwg_div
//
// For each output position beat the unit returns the clipped input window (first in-range
// input index, first in-range tap, tap count) together with the output length and the left
// and right padding of the configured valid, same or explicit-symmetric rule. One beat is
// accepted every cycle while the pipeline is not held. The unit is built from three 17-stage
// bit-per-stage dividers (output length by stride, then the two window ends by dilation side
// by side) plus six single-register stages for the multiplies, padding, clipping and
// output around them. The pipeline advances as a whole: it holds while a result sits on the
// output and the sink stalls. Configuration is taken at once and is used by the next beat
// that enters; write it only while the pipeline is empty. Zero length, kernel, stride or
// dilation read as one; padding mode three acts as valid.
module conv1d_window_geometry_unit #(
    parameter int MAX_INPUT_LENGTH = 65535,
    parameter int MAX_KERNEL_SIZE  = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // position beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_output_pos,
    // descriptor beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_first_input_index,
    output logic [7:0]  o_first_tap_offset,
    output logic [7:0]  o_valid_taps,
    output logic [16:0] o_out_length,
    output logic [15:0] o_left_pad,
    output logic [15:0] o_right_pad
);

    // configuration registers
    logic [15:0] r_len_cfg;
    logic [7:0]  r_ks_cfg, r_st_cfg, r_dl_cfg, r_ep_cfg;
    logic [1:0]  r_mode_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg  <= 16'd1;
            r_ks_cfg   <= 8'd1;
            r_st_cfg   <= 8'd1;
            r_dl_cfg   <= 8'd1;
            r_mode_cfg <= 2'd0;
            r_ep_cfg   <= 8'd0;
        end else if (i_cfg_we) begin
            case (cwg_pkg::t_cfg_idx'(i_cfg_idx))
                cwg_pkg::CFG_INPUT_LENGTH:     r_len_cfg  <= i_cfg_data;
                cwg_pkg::CFG_KERNEL_SIZE:      r_ks_cfg   <= i_cfg_data[7:0];
                cwg_pkg::CFG_STRIDE:           r_st_cfg   <= i_cfg_data[7:0];
                cwg_pkg::CFG_DILATION:         r_dl_cfg   <= i_cfg_data[7:0];
                cwg_pkg::CFG_PADDING_MODE:     r_mode_cfg <= i_cfg_data[1:0];
                cwg_pkg::CFG_EXPLICIT_PADDING: r_ep_cfg   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // whole-pipeline advance: hold only while a finished beat is refused
    logic w_en;
    logic r7_vld;
    assign w_en    = !(r7_vld && i_stall);
    assign o_stall = !w_en;

    // stage 1: clean up configuration, effective kernel extent and pos*stride
    logic [15:0] w_len;
    logic [7:0]  w_ks, w_st, w_dl;
    logic [15:0] w_ext;
    logic        r1_vld;
    cwg_pkg::t_geo r1_geo;
    cwg_pkg::t_geo n1_geo;

    always_comb begin
        w_len = (r_len_cfg == 16'd0) ? 16'd1 : r_len_cfg;
        if (32'(w_len) > 32'(MAX_INPUT_LENGTH)) w_len = 16'(MAX_INPUT_LENGTH);
        w_ks = (r_ks_cfg == 8'd0) ? 8'd1 : r_ks_cfg;
        if (32'(w_ks) > 32'(MAX_KERNEL_SIZE)) w_ks = 8'(MAX_KERNEL_SIZE);
        w_st  = (r_st_cfg == 8'd0) ? 8'd1 : r_st_cfg;
        w_dl  = (r_dl_cfg == 8'd0) ? 8'd1 : r_dl_cfg;
        w_ext = w_dl * (w_ks - 8'd1);
        n1_geo      = '0;
        n1_geo.len  = w_len;
        n1_geo.ks   = w_ks;
        n1_geo.st   = w_st;
        n1_geo.dl   = w_dl;
        n1_geo.eff  = {1'b0, w_ext} + 17'd1;
        n1_geo.pp   = i_output_pos * w_st;
        n1_geo.mode = r_mode_cfg;
        n1_geo.ep   = r_ep_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
        if (w_en) begin
            r1_geo <= n1_geo;
        end
    end

    // output-length dividend per padding rule
    logic [16:0] w_num1;
    logic [17:0] w_padded;
    cwg_pkg::t_geo w_geo1;

    always_comb begin
        w_geo1   = r1_geo;
        w_padded = 18'(r1_geo.len) + {9'd0, r1_geo.ep, 1'b0};
        case (cwg_pkg::t_pad_mode'(r1_geo.mode))
            cwg_pkg::PAD_SAME: begin
                w_geo1.ok = 1'b1;
                w_num1    = 17'(r1_geo.len) + 17'(r1_geo.st) - 17'd1;
            end
            cwg_pkg::PAD_EXPLICIT: begin
                w_geo1.ok = (w_padded >= 18'(r1_geo.eff));
                w_num1    = w_geo1.ok ? 17'(w_padded - 18'(r1_geo.eff)) : 17'd0;
            end
            default: begin
                w_geo1.ok = (17'(r1_geo.len) >= r1_geo.eff);
                w_num1    = w_geo1.ok ? 17'(r1_geo.len) - r1_geo.eff : 17'd0;
            end
        endcase
    end

    logic          w_d1_vld;
    logic [16:0]   w_q1;
    cwg_pkg::t_geo w_d1_geo;

    cwg_div #(.DW(cwg_pkg::DIV_W), .SW($bits(cwg_pkg::t_geo))) u_div_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (w_num1),
        .i_den   (r1_geo.st),
        .i_side  (w_geo1),
        .o_valid (w_d1_vld),
        .o_quo   (w_q1),
        .o_side  (w_d1_geo)
    );

    // stage 3: output length and the span product of same mode
    logic          r3_vld;
    cwg_pkg::t_geo r3_geo;
    logic [16:0]   r3_outlen;
    logic [24:0]   r3_prod;
    logic [16:0]   n3_outlen;
    logic [24:0]   n3_prod;

    always_comb begin
        n3_prod = 25'd0;
        if (w_d1_geo.mode == 2'(cwg_pkg::PAD_SAME)) begin
            n3_outlen = w_q1;
            n3_prod   = (w_q1 - 17'd1) * w_d1_geo.st;
        end else begin
            n3_outlen = w_d1_geo.ok ? w_q1 + 17'd1 : 17'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_d1_vld;
        end
        if (w_en) begin
            r3_geo    <= w_d1_geo;
            r3_outlen <= n3_outlen;
            r3_prod   <= n3_prod;
        end
    end

    // stage 4: padding
    logic          r4_vld;
    cwg_pkg::t_geo r4_geo;
    logic [16:0]   r4_outlen;
    logic [15:0]   r4_lpad, r4_rpad;
    logic [24:0]   w_needed;
    logic [16:0]   w_total;
    logic [15:0]   n4_lpad, n4_rpad;

    always_comb begin
        w_needed = 25'(r3_geo.eff) + r3_prod;
        w_total  = (w_needed > 25'(r3_geo.len)) ? 17'(w_needed - 25'(r3_geo.len)) : 17'd0;
        case (cwg_pkg::t_pad_mode'(r3_geo.mode))
            cwg_pkg::PAD_SAME: begin
                n4_lpad = w_total[16:1];
                n4_rpad = 16'(w_total - {1'b0, w_total[16:1]});
            end
            cwg_pkg::PAD_EXPLICIT: begin
                n4_lpad = 16'(r3_geo.ep);
                n4_rpad = 16'(r3_geo.ep);
            end
            default: begin
                n4_lpad = 16'd0;
                n4_rpad = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
        if (w_en) begin
            r4_geo    <= r3_geo;
            r4_outlen <= r3_outlen;
            r4_lpad   <= n4_lpad;
            r4_rpad   <= n4_rpad;
        end
    end

    // stage 5: window start and the two tap dividends
    logic          r5_vld;
    cwg_pkg::t_win r5_win;
    logic [16:0]   r5_fk_num, r5_mk_num;
    cwg_pkg::t_win n5_win;
    logic [25:0]   w_span;

    always_comb begin
        n5_win        = '0;
        n5_win.start  = 26'($signed({2'b0, r4_geo.pp}) - $signed({10'b0, r4_lpad}));
        n5_win.ks     = r4_geo.ks;
        n5_win.dl     = r4_geo.dl;
        n5_win.neg    = n5_win.start[25];
        n5_win.inr    = ($signed(n5_win.start) < $signed({10'b0, r4_geo.len}));
        n5_win.outlen = r4_outlen;
        n5_win.lpad   = r4_lpad;
        n5_win.rpad   = r4_rpad;
        w_span        = 26'({10'b0, r4_geo.len}) - 26'd1 - n5_win.start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
        if (w_en) begin
            r5_win    <= n5_win;
            r5_fk_num <= n5_win.neg ? 17'(26'd0 - n5_win.start + 26'(r4_geo.dl) - 26'd1)
                                    : 17'd0;
            r5_mk_num <= n5_win.inr ? w_span[16:0] : 17'd0;
        end
    end

    logic          w_d2_vld, w_d3_vld;
    logic [16:0]   w_q2, w_q3;
    logic          w_d2_neg;
    cwg_pkg::t_win w_d3_win;

    // first tap: ceil of the part before the input over dilation
    cwg_div #(.DW(cwg_pkg::DIV_W), .SW(1)) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_vld),
        .i_num   (r5_fk_num),
        .i_den   (r5_win.dl),
        .i_side  (r5_win.neg),
        .o_valid (w_d2_vld),
        .o_quo   (w_q2),
        .o_side  (w_d2_neg)
    );

    // last tap that still lands inside the input
    cwg_div #(.DW(cwg_pkg::DIV_W), .SW($bits(cwg_pkg::t_win))) u_div_last (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_vld),
        .i_num   (r5_mk_num),
        .i_den   (r5_win.dl),
        .i_side  (r5_win),
        .o_valid (w_d3_vld),
        .o_quo   (w_q3),
        .o_side  (w_d3_win)
    );

    // stage 6: clip taps, offset product
    logic          r6_vld;
    cwg_pkg::t_win r6_win;
    logic [16:0]   r6_fk, r6_lk;
    logic          r6_empty;
    logic [24:0]   r6_prod;
    logic [16:0]   n6_fk, n6_lk;

    always_comb begin
        n6_fk = w_d2_neg ? w_q2 : 17'd0;
        n6_lk = 17'(w_d3_win.ks) - 17'd1;
        if (w_q3 < n6_lk) n6_lk = w_q3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= w_d2_vld && w_d3_vld;
        end
        if (w_en) begin
            r6_win   <= w_d3_win;
            r6_fk    <= n6_fk;
            r6_lk    <= n6_lk;
            r6_empty <= !w_d3_win.inr || (n6_fk > n6_lk);
            r6_prod  <= n6_fk * w_d3_win.dl;
        end
    end

    // stage 7: output register
    logic [7:0] r7_ks;
    logic [25:0] w_first;
    assign w_first = r6_win.start + 26'(r6_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
        end
        if (w_en) begin
            r7_ks               <= r6_win.ks;
            o_first_input_index <= r6_empty ? 16'd0 : w_first[15:0];
            o_first_tap_offset  <= r6_empty ? r6_win.ks : r6_fk[7:0];
            o_valid_taps        <= r6_empty ? 8'd0 : 8'(r6_lk - r6_fk + 17'd1);
            o_out_length        <= r6_win.outlen;
            o_left_pad          <= r6_win.lpad;
            o_right_pad         <= r6_win.rpad;
        end
    end

    assign o_valid = r7_vld;

`ifndef SYNTHESIS
    // the pipeline only holds because of a refused result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("pipeline held without a waiting result");

    // an empty window reports index zero and the kernel size as offset
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_taps == 8'd0) |->
            (o_first_input_index == 16'd0 && o_first_tap_offset == r7_ks))
        else $error("empty window descriptor malformed");

    // taps never run past the end of the kernel
    a_taps_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_taps != 8'd0) |->
            ((9'(o_first_tap_offset) + 9'(o_valid_taps)) <= 9'(r7_ks)))
        else $error("window taps exceed kernel size");
`endif

endmodule

### src/cwg_div.sv
// cwg_div: pipelined restoring divider, one quotient bit per stage
// divides by an 8-bit divisor, carries a sideband word alongside; uses no package
module cwg_div #(
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [7:0]    i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_q    [DW];
    logic [7:0]    r_rem  [DW];
    logic [7:0]    r_den  [DW];
    logic [SW-1:0] r_side [DW];
    logic          r_vld  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0] w_q;
        logic [7:0]    w_rem;
        logic [7:0]    w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [8:0]    w_trial;
        logic          w_ge;
        logic [DW-1:0] n_q;
        logic [7:0]    n_rem;

        if (k == 0) begin : g_first
            assign w_q    = i_num;
            assign w_rem  = 8'd0;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_q    = r_q[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        always_comb begin
            w_trial = {w_rem, w_q[DW-1]};
            w_ge    = (w_trial >= {1'b0, w_den});
            n_rem   = w_ge ? 8'(w_trial - {1'b0, w_den}) : w_trial[7:0];
            n_q     = {w_q[DW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
            if (i_en) begin
                r_q[k]    <= n_q;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_quo   = r_q[DW-1];
    assign o_side  = r_side[DW-1];

endmodule
